// ===== src/chbm_pkg.sv =====
// shared types, constants and codes for the cell health and balance monitor
`default_nettype none
package chbm_pkg;

	localparam int NUM_CELLS = 6;
	localparam int VOLT_W    = 13;
	localparam int TEMP_W    = 8;
	localparam int CUR_W     = 16;
	localparam int HEALTH_W  = 3;

	// stream payload layout
	localparam int IN_BITS  = NUM_CELLS * VOLT_W + TEMP_W + CUR_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int TEMP_LSB = NUM_CELLS * VOLT_W;
	localparam int CUR_LSB  = TEMP_LSB + TEMP_W;
	localparam int OUT_BITS = 5 * NUM_CELLS + 1 + HEALTH_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// config port
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	typedef logic [VOLT_W-1:0]    volt_t;
	typedef logic [NUM_CELLS-1:0] cell_mask_t;

	localparam volt_t VOLT_MAX = {VOLT_W{1'b1}};

	typedef enum logic [HEALTH_W-1:0] {
		HEALTH_GOOD         = 3'd0,
		HEALTH_OVERHEAT     = 3'd1,
		HEALTH_OVER_DELTA   = 3'd2,
		HEALTH_OVER_VOLT    = 3'd3,
		HEALTH_DEAD         = 3'd4,
		HEALTH_OVER_CURRENT = 3'd5
	} health_t;

	typedef enum logic [2:0] {
		REG_MAX_TEMP     = 3'd0,
		REG_MAX_VOLT     = 3'd1,
		REG_MIN_VOLT     = 3'd2,
		REG_DELTA_TRIP   = 3'd3,
		REG_BAL_DELTA    = 3'd4,
		REG_MAX_CURRENT  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] max_temperature;
		volt_t                    max_cell_voltage;
		volt_t                    min_cell_voltage;
		volt_t                    delta_trip;
		volt_t                    balance_delta;
		logic [CUR_W-1:0]         max_current;
	} cfg_t;

	localparam logic signed [TEMP_W-1:0] RST_MAX_TEMP    = 8'sd60;
	localparam volt_t                    RST_MAX_VOLT    = 13'd4200;
	localparam volt_t                    RST_MIN_VOLT    = 13'd3000;
	localparam volt_t                    RST_DELTA_TRIP  = 13'd300;
	localparam volt_t                    RST_BAL_DELTA   = 13'd20;
	localparam logic [CUR_W-1:0]         RST_MAX_CURRENT = 16'd30000;

	typedef struct packed {
		logic over_delta;
		logic over_volt;
		logic under_volt;
		logic want_bal;
	} lane_flags_t;

	typedef struct packed {
		logic       shutdown;
		health_t    health;
		logic       overheat;
		cell_mask_t under_voltage_mask;
		cell_mask_t over_voltage_mask;
		cell_mask_t over_delta_mask;
		cell_mask_t balance_off_mask;
		cell_mask_t balance_on_mask;
	} result_t;

endpackage
`default_nettype wire

// ===== src/chbm_min.sv =====
// registered-free minimum tree over the cell voltages of one request
`default_nettype none
module chbm_min (
	input  chbm_pkg::volt_t volt [chbm_pkg::NUM_CELLS],
	output chbm_pkg::volt_t lowest
);
	import chbm_pkg::*;

	localparam int LEVELS = $clog2(NUM_CELLS);
	localparam int PAD    = 1 << LEVELS;

	volt_t node [LEVELS+1][PAD];

	always_comb begin
		for (int l = 0; l <= LEVELS; l++) begin
			for (int k = 0; k < PAD; k++) begin
				node[l][k] = VOLT_MAX;
			end
		end
		for (int k = 0; k < NUM_CELLS; k++) begin
			node[0][k] = volt[k];
		end
		// pairwise compare, one level per pass
		for (int l = 0; l < LEVELS; l++) begin
			for (int k = 0; k < (PAD >> (l + 1)); k++) begin
				node[l+1][k] = (node[l][2*k+1] < node[l][2*k]) ?
					node[l][2*k+1] : node[l][2*k];
			end
		end
	end

	assign lowest = node[LEVELS][0];

endmodule
`default_nettype wire

// ===== src/chbm_lane.sv =====
// per-cell checks: delta above lowest, voltage limits and balancing wish
`default_nettype none
module chbm_lane (
	input  chbm_pkg::volt_t     volt,
	input  chbm_pkg::volt_t     lowest,
	input  chbm_pkg::cfg_t      cfg,
	output chbm_pkg::lane_flags_t flags
);
	import chbm_pkg::*;

	volt_t delta;

	// lowest never exceeds volt, so no borrow
	assign delta = volt - lowest;

	always_comb begin
		flags.over_delta = delta > cfg.delta_trip;
		flags.over_volt  = volt > cfg.max_cell_voltage;
		flags.under_volt = volt < cfg.min_cell_voltage;
		flags.want_bal   = (delta > cfg.balance_delta) || (volt > cfg.max_cell_voltage);
	end

endmodule
`default_nettype wire

// ===== src/chbm_merge.sv =====
// combines lane flags into masks, pack health and next state
`default_nettype none
module chbm_merge (
	input  chbm_pkg::lane_flags_t            flags [chbm_pkg::NUM_CELLS],
	input  logic signed [chbm_pkg::TEMP_W-1:0] temperature,
	input  logic [chbm_pkg::CUR_W-1:0]       current,
	input  chbm_pkg::cfg_t                   cfg,
	input  chbm_pkg::cell_mask_t             balancing,
	input  logic                             shutdown_now,
	output chbm_pkg::result_t                res,
	output chbm_pkg::cell_mask_t             want_mask
);
	import chbm_pkg::*;

	cell_mask_t odelta;
	cell_mask_t ovolt;
	cell_mask_t uvolt;
	logic       heat;
	logic       ocur;
	health_t    health;

	always_comb begin
		for (int k = 0; k < NUM_CELLS; k++) begin
			odelta[k]    = flags[k].over_delta;
			ovolt[k]     = flags[k].over_volt;
			uvolt[k]     = flags[k].under_volt;
			want_mask[k] = flags[k].want_bal;
		end
	end

	assign heat = temperature > cfg.max_temperature;
	assign ocur = current > cfg.max_current;

	always_comb begin
		if (ocur) begin
			health = HEALTH_OVER_CURRENT;
		end else if (|uvolt) begin
			health = HEALTH_DEAD;
		end else if (|ovolt) begin
			health = HEALTH_OVER_VOLT;
		end else if (|odelta) begin
			health = HEALTH_OVER_DELTA;
		end else if (heat) begin
			health = HEALTH_OVERHEAT;
		end else begin
			health = HEALTH_GOOD;
		end
	end

	always_comb begin
		res.balance_on_mask    = want_mask & ~balancing;
		res.balance_off_mask   = ~want_mask & balancing;
		res.over_delta_mask    = odelta;
		res.over_voltage_mask  = ovolt;
		res.under_voltage_mask = uvolt;
		res.overheat           = heat;
		res.health             = health;
		res.shutdown           = shutdown_now || (health != HEALTH_GOOD);
	end

endmodule
`default_nettype wire

// ===== src/cell_health_and_balance_monitor_unit.sv =====
// top level of the cell health and balance monitor: stream pipeline and config registers
// a request is registered in stage 1 and then in the output register, which holds
// its result until taken; throughput: one request per cycle while m_tready is high;
// s_tready follows m_tready through the two stages
// stage 1 holds the voltages and the lowest voltage from the min tree,
// stage 2 runs the per-cell lanes and the merge into the output register
// reset (arst_n low, asynchronous): pipeline empty, balancing mask and shutdown
// latch cleared, thresholds back to 60 C, 4200, 3000, 300, 20 mV and 30000 mA
`default_nettype none
module cell_health_and_balance_monitor_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cell0_voltage .. cell5_voltage, pack_temperature, pack_current, zero pad
	input  logic [chbm_pkg::IN_W-1:0]     s_tdata,
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// balance_on_mask, balance_off_mask, over_delta_mask, over_voltage_mask,
	// under_voltage_mask, overheat, pack_health, shutdown, zero pad
	output logic [chbm_pkg::OUT_W-1:0]    m_tdata,
	// config port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [chbm_pkg::ADDR_W-1:0]   paddr,
	input  logic [chbm_pkg::DATA_W-1:0]   pwdata,
	output logic [chbm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import chbm_pkg::*;

	// config registers
	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	// input unpacking
	volt_t                    in_volt [NUM_CELLS];
	volt_t                    in_lowest;

	// stage 1
	logic                     valid_s1;
	volt_t                    volt_s1 [NUM_CELLS];
	volt_t                    lowest_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic [CUR_W-1:0]         cur_s1;

	// stage 2 / output
	logic                     valid_s2;
	result_t                  res_s2;
	result_t                  res_next;
	lane_flags_t              flags [NUM_CELLS];
	cell_mask_t               want_mask;

	// pack state
	cell_mask_t               balancing_q;
	logic                     shutdown_q;

	logic                     adv_s2;
	logic                     adv_s1;

	// ---------------- config port ----------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_temperature  <= RST_MAX_TEMP;
			cfg_q.max_cell_voltage <= RST_MAX_VOLT;
			cfg_q.min_cell_voltage <= RST_MIN_VOLT;
			cfg_q.delta_trip       <= RST_DELTA_TRIP;
			cfg_q.balance_delta    <= RST_BAL_DELTA;
			cfg_q.max_current      <= RST_MAX_CURRENT;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_MAX_TEMP:    cfg_q.max_temperature  <= pwdata[TEMP_W-1:0];
				REG_MAX_VOLT:    cfg_q.max_cell_voltage <= pwdata[VOLT_W-1:0];
				REG_MIN_VOLT:    cfg_q.min_cell_voltage <= pwdata[VOLT_W-1:0];
				REG_DELTA_TRIP:  cfg_q.delta_trip       <= pwdata[VOLT_W-1:0];
				REG_BAL_DELTA:   cfg_q.balance_delta    <= pwdata[VOLT_W-1:0];
				REG_MAX_CURRENT: cfg_q.max_current      <= pwdata[CUR_W-1:0];
				default: ; // addresses past the last register are ignored
			endcase
		end
	end

	// read back, temperature limit sign-extended
	always_comb begin
		unique case (reg_idx)
			REG_MAX_TEMP: prdata = DATA_W'(signed'(cfg_q.max_temperature));
			REG_MAX_VOLT: prdata = DATA_W'(cfg_q.max_cell_voltage);
			REG_MIN_VOLT: prdata = DATA_W'(cfg_q.min_cell_voltage);
			REG_DELTA_TRIP: prdata = DATA_W'(cfg_q.delta_trip);
			REG_BAL_DELTA: prdata = DATA_W'(cfg_q.balance_delta);
			REG_MAX_CURRENT: prdata = DATA_W'(cfg_q.max_current);
			default: prdata = '0;
		endcase
	end

	// ---------------- pipeline flow ----------------
	// the output register frees when empty or taken; stage 1 moves on behind it
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	// ---------------- stage 1: lowest voltage ----------------
	always_comb begin
		for (int k = 0; k < NUM_CELLS; k++) begin
			in_volt[k] = s_tdata[k*VOLT_W +: VOLT_W];
		end
	end

	chbm_min u_min (
		.volt   (in_volt),
		.lowest (in_lowest)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			volt_s1   <= in_volt;
			lowest_s1 <= in_lowest;
			temp_s1   <= s_tdata[TEMP_LSB +: TEMP_W];
			cur_s1    <= s_tdata[CUR_LSB +: CUR_W];
		end
	end

	// ---------------- stage 2: lanes and merge ----------------
	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_lane
		chbm_lane u_lane (
			.volt   (volt_s1[g]),
			.lowest (lowest_s1),
			.cfg    (cfg_q),
			.flags  (flags[g])
		);
	end

	chbm_merge u_merge (
		.flags        (flags),
		.temperature  (temp_s1),
		.current      (cur_s1),
		.cfg          (cfg_q),
		.balancing    (balancing_q),
		.shutdown_now (shutdown_q),
		.res          (res_next),
		.want_mask    (want_mask)
	);

	// pack state moves with the request that enters the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			balancing_q <= '0;
			shutdown_q  <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				balancing_q <= want_mask;
				shutdown_q  <= res_next.shutdown;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_W'(res_s2);

	// ---------------- checks ----------------
	// the shutdown latch only clears through reset
	a_latch_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(shutdown_q))
		else $error("shutdown latch cleared without reset");

	// any fault in a presented result comes with shutdown set
	a_fault_shuts: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.health != HEALTH_GOOD) |-> res_s2.shutdown)
		else $error("fault reported without shutdown");

	// a cell cannot switch balancing on and off in the same result
	a_on_off_apart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((res_s2.balance_on_mask & res_s2.balance_off_mask) == '0))
		else $error("balancing switched on and off together");

	// over-voltage cells force at least an over-voltage health code
	a_ovolt_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (|res_s2.over_voltage_mask)) |->
		(res_s2.health == HEALTH_OVER_VOLT || res_s2.health == HEALTH_DEAD ||
		 res_s2.health == HEALTH_OVER_CURRENT))
		else $error("over-voltage ranked too low");

	// the stored balancing set is what the last result left
	a_bal_track: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && valid_s1) |=>
		(balancing_q == (($past(balancing_q) | res_s2.balance_on_mask) &
		 ~res_s2.balance_off_mask)))
		else $error("balancing mask out of step with reported changes");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the cell health and balance monitor
`default_nettype none
module testbench;
	import chbm_pkg::*;

	localparam int LATENCY     = 2;
	localparam int SETTLE      = LATENCY + 4;
	localparam int STALL_LIMIT = 1000;
	localparam int IDLE_PCT    = 37;
	localparam int REPORT_MAX  = 10;

	// one measurement set, laid out exactly as s_tdata carries it (cell 0 in the lowest bits)
	typedef struct packed {
		logic [CUR_W-1:0]         cur;
		logic signed [TEMP_W-1:0] temp;
		volt_t [NUM_CELLS-1:0]    volts;
	} meas_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	cell_health_and_balance_monitor_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow thresholds, kept in step with every register write
	logic signed [TEMP_W-1:0] lim_temp = RST_MAX_TEMP;
	volt_t                    lim_vmax = RST_MAX_VOLT;
	volt_t                    lim_vmin = RST_MIN_VOLT;
	volt_t                    lim_delta_trip = RST_DELTA_TRIP;
	volt_t                    lim_bal_delta = RST_BAL_DELTA;
	logic [CUR_W-1:0]         lim_cur = RST_MAX_CURRENT;

	// shadow of the block's own state
	cell_mask_t balancing_cells = '0;
	logic       latched_shutdown = 1'b0;

	meas_t   measurement_queue[$];
	result_t expected_status[$];
	meas_t   in_flight;
	result_t seen_status;
	result_t due_status;
	bit      no_idle = 1'b0;
	int      mismatches = 0;
	int      stall_cycles = 0;

	// status the block must report for one measurement set; advances the shadow state
	function automatic result_t predict_status(meas_t m);
		result_t    r;
		volt_t      lowest;
		volt_t      gap;
		cell_mask_t wanted;
		r = '0;
		lowest = VOLT_MAX;
		wanted = '0;
		// lowest cell over all cells, wherever it sits
		for (int i = 0; i < NUM_CELLS; i++)
			if (m.volts[i] < lowest)
				lowest = m.volts[i];
		for (int i = 0; i < NUM_CELLS; i++) begin
			gap = m.volts[i] - lowest;
			r.over_delta_mask[i]    = gap > lim_delta_trip;
			r.over_voltage_mask[i]  = m.volts[i] > lim_vmax;
			r.under_voltage_mask[i] = m.volts[i] < lim_vmin;
			// balance on a large delta or on a cell that is simply too high
			wanted[i] = (gap > lim_bal_delta) || (m.volts[i] > lim_vmax);
		end
		r.overheat = $signed(m.temp) > $signed(lim_temp);
		// highest-ranking condition wins
		if (m.cur > lim_cur)
			r.health = HEALTH_OVER_CURRENT;
		else if (|r.under_voltage_mask)
			r.health = HEALTH_DEAD;
		else if (|r.over_voltage_mask)
			r.health = HEALTH_OVER_VOLT;
		else if (|r.over_delta_mask)
			r.health = HEALTH_OVER_DELTA;
		else if (r.overheat)
			r.health = HEALTH_OVERHEAT;
		else
			r.health = HEALTH_GOOD;
		if (r.health != HEALTH_GOOD)
			latched_shutdown = 1'b1;
		r.balance_on_mask  = wanted & ~balancing_cells;
		r.balance_off_mask = ~wanted & balancing_cells;
		balancing_cells = wanted;
		r.shutdown = latched_shutdown;
		return r;
	endfunction

	task automatic note_mismatch(string what, longint unsigned want, longint unsigned got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch %s: expected %0d, got %0d", what, want, got);
	endtask

	task automatic check_field(string what, longint unsigned want, longint unsigned got);
		if (want != got)
			note_mismatch(what, want, got);
	endtask

	// request side: holds tvalid and data until taken, idles at random between requests
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_status.push_back(predict_status(in_flight));
			if (!s_tvalid || s_tready) begin
				if (measurement_queue.size() != 0
						&& (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					in_flight = measurement_queue.pop_front();
					s_tdata  <= IN_W'(in_flight);
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side: random back-pressure, every taken result checked against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_status = result_t'(m_tdata[OUT_BITS-1:0]);
				if (expected_status.size() == 0) begin
					note_mismatch("result with nothing outstanding", 0, seen_status);
				end else begin
					due_status = expected_status.pop_front();
					check_field("balance_on_mask", due_status.balance_on_mask,
						seen_status.balance_on_mask);
					check_field("balance_off_mask", due_status.balance_off_mask,
						seen_status.balance_off_mask);
					check_field("over_delta_mask", due_status.over_delta_mask,
						seen_status.over_delta_mask);
					check_field("over_voltage_mask", due_status.over_voltage_mask,
						seen_status.over_voltage_mask);
					check_field("under_voltage_mask", due_status.under_voltage_mask,
						seen_status.under_voltage_mask);
					check_field("overheat", due_status.overheat, seen_status.overheat);
					check_field("pack_health", due_status.health, seen_status.health);
					check_field("shutdown", due_status.shutdown, seen_status.shutdown);
				end
			end
			m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// cycles in which nothing moves on any port
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("FAIL cell_health_and_balance_monitor_unit");
		$finish;
	end

	// apb write of one threshold, then a read back of it
	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		logic [DATA_W-1:0] keep;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register taken at this edge
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_MAX_TEMP:    begin lim_temp       = val[TEMP_W-1:0]; keep = 32'h0000_00ff; end
			REG_MAX_VOLT:    begin lim_vmax       = val[VOLT_W-1:0]; keep = 32'h0000_1fff; end
			REG_MIN_VOLT:    begin lim_vmin       = val[VOLT_W-1:0]; keep = 32'h0000_1fff; end
			REG_DELTA_TRIP:  begin lim_delta_trip = val[VOLT_W-1:0]; keep = 32'h0000_1fff; end
			REG_BAL_DELTA:   begin lim_bal_delta  = val[VOLT_W-1:0]; keep = 32'h0000_1fff; end
			REG_MAX_CURRENT: begin lim_cur        = val[CUR_W-1:0];  keep = 32'h0000_ffff; end
			default:         keep = '0;
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("register read back", val & keep, prdata & keep);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_limits(int t, int vmax, int vmin, int dmax, int dbal, int cur);
		reg_write(REG_MAX_TEMP, DATA_W'(t));
		reg_write(REG_MAX_VOLT, DATA_W'(vmax));
		reg_write(REG_MIN_VOLT, DATA_W'(vmin));
		reg_write(REG_DELTA_TRIP, DATA_W'(dmax));
		reg_write(REG_BAL_DELTA, DATA_W'(dbal));
		reg_write(REG_MAX_CURRENT, DATA_W'(cur));
	endtask

	task automatic program_typical();
		program_limits($urandom_range(100) - 20, $urandom_range(3900, 4400),
			$urandom_range(2500, 3200), $urandom_range(50, 500), $urandom_range(0, 60),
			$urandom_range(10000, 50000));
	endtask

	// waits until every queued request has been sent and every result taken, then a settle gap
	task automatic drain();
		while (measurement_queue.size() != 0 || s_tvalid || expected_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic int clamp(int v, int lo, int hi);
		return (v < lo) ? lo : (v > hi) ? hi : v;
	endfunction

	function automatic meas_t make_set(int c0, int c1, int c2, int c3, int c4, int c5,
			int t, int i);
		meas_t m;
		m.volts[0] = VOLT_W'(c0); m.volts[1] = VOLT_W'(c1); m.volts[2] = VOLT_W'(c2);
		m.volts[3] = VOLT_W'(c3); m.volts[4] = VOLT_W'(c4); m.volts[5] = VOLT_W'(c5);
		m.temp = TEMP_W'(t);
		m.cur  = CUR_W'(i);
		return m;
	endfunction

	// mostly plausible packs centred on the current thresholds, some raw noise
	function automatic meas_t random_set();
		meas_t m;
		int    lo;
		int    hi;
		int    base;
		int    spread;
		if ($urandom_range(99) < 30) begin
			for (int i = 0; i < NUM_CELLS; i++)
				m.volts[i] = VOLT_W'($urandom_range(0, 8191));
			m.temp = TEMP_W'($urandom);
			m.cur  = CUR_W'($urandom);
			return m;
		end
		lo = (lim_vmin < lim_vmax) ? int'(lim_vmin) : int'(lim_vmax);
		hi = (lim_vmin < lim_vmax) ? int'(lim_vmax) : int'(lim_vmin);
		base = $urandom_range(clamp(lo - 200, 0, 8191), clamp(hi + 200, 0, 8191));
		spread = $urandom_range(1) ? 2 * int'(lim_bal_delta) + 2
			: int'(lim_delta_trip) + int'(lim_delta_trip) / 4 + 2;
		for (int i = 0; i < NUM_CELLS; i++)
			m.volts[i] = VOLT_W'(clamp(base + int'($urandom_range(0, spread)), 0, 8191));
		// now and then one weak cell
		if ($urandom_range(9) == 0)
			m.volts[$urandom_range(NUM_CELLS - 1)] =
				VOLT_W'(clamp(base - int'($urandom_range(600)), 0, 8191));
		m.temp = TEMP_W'(clamp(int'(lim_temp) + int'($urandom_range(0, 10)) - 5, -128, 127));
		m.cur  = CUR_W'(clamp(int'(lim_cur) + int'($urandom_range(0, 4000)) - 2000, 0, 65535));
		return m;
	endfunction

	task automatic queue_random(int n);
		repeat (n) measurement_queue.push_back(random_set());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets under the reset thresholds: healthy first, so the latch is seen clear
		measurement_queue.push_back(make_set(3700, 3700, 3700, 3700, 3700, 3700, 25, 1000));
		measurement_queue.push_back(make_set(3700, 3730, 3700, 3700, 3700, 3700, 25, 1000));
		measurement_queue.push_back(make_set(3700, 3730, 3700, 3700, 3700, 3700, 25, 1000));
		measurement_queue.push_back(make_set(3700, 3700, 3700, 3700, 3700, 3721, 25, 1000));
		// every threshold met exactly, nothing trips
		measurement_queue.push_back(make_set(4200, 4200, 4200, 4200, 4200, 4200, 60, 30000));
		measurement_queue.push_back(make_set(3000, 3020, 3300, 3000, 3000, 3000, -1, 0));
		// one condition each, then all together
		measurement_queue.push_back(make_set(3700, 3700, 3700, 3700, 3700, 3700, 61, 1000));
		measurement_queue.push_back(make_set(3100, 3401, 3100, 3100, 3100, 3100, 25, 1000));
		measurement_queue.push_back(make_set(4190, 4190, 4190, 4190, 4190, 4201, 25, 1000));
		measurement_queue.push_back(make_set(3500, 3500, 2999, 3500, 3500, 3500, 25, 1000));
		measurement_queue.push_back(make_set(3700, 3700, 3700, 3700, 3700, 3700, 25, 30001));
		measurement_queue.push_back(make_set(4300, 2000, 3700, 3700, 3700, 3700, 100, 40000));
		// lowest cell at either end
		measurement_queue.push_back(make_set(3700, 3700, 3700, 3700, 3700, 3400, 25, 1000));
		measurement_queue.push_back(make_set(3400, 3700, 3700, 3700, 3700, 3700, 25, 1000));
		// field extremes and bit patterns
		measurement_queue.push_back(make_set(0, 0, 0, 0, 0, 0, -128, 0));
		measurement_queue.push_back(make_set(8191, 8191, 8191, 8191, 8191, 8191, 127, 65535));
		measurement_queue.push_back(make_set(0, 8191, 0, 8191, 0, 8191, 0, 32768));
		measurement_queue.push_back(make_set(8191, 0, 8191, 0, 8191, 0, -128, 65535));
		measurement_queue.push_back(make_set(2999, 2999, 4201, 4201, 3600, 3600, 60, 29999));
		measurement_queue.push_back(make_set('h1555, 'h0aaa, 'h1555, 'h0aaa, 'h1555, 'h0aaa,
			'sh55, 'haaaa));
		measurement_queue.push_back(make_set('h0aaa, 'h1555, 'h0aaa, 'h1555, 'h0aaa, 'h1555,
			-86, 'h5555));
		drain();

		// plausible thresholds
		program_typical();
		queue_random(320);
		drain();

		// every threshold at its floor
		program_limits(-128, 0, 0, 0, 0, 0);
		queue_random(80);
		drain();

		// every threshold at its ceiling
		program_limits(127, 8191, 8191, 8191, 8191, 65535);
		queue_random(80);
		drain();

		// thresholds anywhere in range
		repeat (3) begin
			program_limits(int'($urandom_range(255)) - 128, $urandom_range(8191),
				$urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
				$urandom_range(65535));
			queue_random(120);
			drain();
		end

		// long stretch at full rate on both sides
		program_typical();
		no_idle = 1'b1;
		queue_random(300);
		drain();

		if (mismatches == 0)
			$display("PASS cell_health_and_balance_monitor_unit");
		else
			$display("FAIL cell_health_and_balance_monitor_unit");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
src/chbm_pkg.sv
src/chbm_min.sv
src/chbm_lane.sv
src/chbm_merge.sv
src/cell_health_and_balance_monitor_unit.sv
dv/testbench.sv
